[design/msa_pkg.sv]
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants, types and helpers of the metric set aggregator.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int MAX_METRICS     = 64;
  localparam int RECOMPUTE_LIMIT = 16;

  localparam int VAL_W   = 48;
  localparam int ID_W    = 32;
  localparam int CMD_W   = 2;
  localparam int MODE_W  = 2;
  localparam int LVL_W   = 2;
  localparam int CFG_A_W = 2;
  localparam int IDX_W   = (MAX_METRICS > 1) ? $clog2(MAX_METRICS) : 1;
  localparam int SCAN_W  = $clog2(MAX_METRICS + 1);
  localparam int CNT_W   = $clog2(MAX_METRICS + 1);
  localparam int RC_W    = $clog2(RECOMPUTE_LIMIT + 1);
  localparam int ACC_W   = VAL_W + CNT_W;
  localparam int DW      = ACC_W + 1;
  localparam int DCNT_W  = $clog2(DW + 1);

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_AVG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd3;

  localparam logic [LVL_W-1:0] LVL_OK       = 2'd0;
  localparam logic [LVL_W-1:0] LVL_WARNING  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_CRITICAL = 2'd2;
  localparam logic [LVL_W-1:0] LVL_UNKNOWN  = 2'd3;

  localparam logic [CFG_A_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_WARN = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_CRIT = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [DW-1:0]    wide_t;

  localparam wide_t Q_MAX_W = {{(DW - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
  localparam wide_t Q_MIN_W = ~Q_MAX_W;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic search_run;
    logic full_run;
    logic exec;
    logic full_fin;
    logic div_full_start;
    logic div_part_start;
    logic div_full_fin;
    logic div_part_fin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic upd_live;
    logic need_full;
    logic avg_mode;
    logic n_zero;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

  function automatic wide_t ext_val(input val_t v);
    return {{(DW - VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic acc_t acc_of_val(input val_t v);
    return {{(ACC_W - VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic val_t sat_val(input wide_t v);
    if (v > Q_MAX_W) begin
      return Q_MAX_W[VAL_W-1:0];
    end else if (v < Q_MIN_W) begin
      return Q_MIN_W[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

[design/msa_div.sv]
// ----------------------------------------------------------------------------
// msa_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module msa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  msa_pkg::wide_t              dividend,
  input  logic [msa_pkg::CNT_W-1:0]   divisor,
  output msa_pkg::wide_t              quotient,
  output logic                        done
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [msa_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [msa_pkg::DW-1:0]      mag_r;
  logic [msa_pkg::CNT_W-1:0]   rem_r;
  logic [msa_pkg::CNT_W-1:0]   div_r;
  logic                        neg_r;
  logic [msa_pkg::CNT_W:0]     trial;
  logic [msa_pkg::CNT_W:0]     trial_sub;
  logic                        qbit;

  assign trial     = {rem_r, mag_r[msa_pkg::DW-1]};
  assign qbit      = (trial >= {1'b0, div_r});
  assign trial_sub = qbit ? (trial - {1'b0, div_r}) : trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = msa_pkg::DCNT_W'(msa_pkg::DW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == msa_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[msa_pkg::DW-1];
      mag_r <= dividend[msa_pkg::DW-1] ? (-dividend) : dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      // shift quotient bits in from the bottom as dividend bits leave the top
      mag_r <= {mag_r[msa_pkg::DW-2:0], qbit};
      rem_r <= trial_sub[msa_pkg::CNT_W-1:0];
    end
  end

  assign quotient = neg_r ? -msa_pkg::wide_t'(mag_r) : msa_pkg::wide_t'(mag_r);
  assign done     = done_r;

endmodule

[design/msa_datapath.sv]
// ----------------------------------------------------------------------------
// msa_datapath
// Metric table, scan pipeline, aggregate registers, config and result word.
// ----------------------------------------------------------------------------
module msa_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msa_pkg::dp_cmd_t              cmd,
  output msa_pkg::dp_stat_t             stat,
  input  logic [msa_pkg::CMD_W-1:0]     in_command,
  input  logic [msa_pkg::ID_W-1:0]      in_metric_id,
  input  msa_pkg::val_t                 in_metric_value,
  input  logic                          cfg_valid,
  input  logic [msa_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [msa_pkg::VAL_W-1:0]     cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output msa_pkg::val_t                 out_aggregate_value,
  output logic                          out_value_unknown,
  output logic [msa_pkg::LVL_W-1:0]     out_level_state,
  output logic                          out_level_changed
);

  // table
  logic [msa_pkg::ID_W-1:0]   id_mem  [msa_pkg::MAX_METRICS];
  msa_pkg::val_t              val_mem [msa_pkg::MAX_METRICS];
  logic [msa_pkg::ID_W-1:0]   rd_id_r;
  msa_pkg::val_t              rd_val_r;
  logic                       mem_we;
  logic [msa_pkg::IDX_W-1:0]  mem_wa;
  logic [msa_pkg::ID_W-1:0]   mem_wid;
  msa_pkg::val_t              mem_wval;
  logic [msa_pkg::MAX_METRICS-1:0] valid_r;
  logic [msa_pkg::CNT_W-1:0]  count_r;

  // item
  logic [msa_pkg::CMD_W-1:0]  cmd_r;
  logic [msa_pkg::ID_W-1:0]   id_r;
  msa_pkg::val_t              nv_r;
  msa_pkg::val_t              ov_r;
  logic                       found_r;
  logic [msa_pkg::IDX_W-1:0]  slot_r;
  logic                       free_found_r;
  logic [msa_pkg::IDX_W-1:0]  free_slot_r;

  // scan
  logic [msa_pkg::SCAN_W-1:0] scan_r;
  logic                       pipe_vld_r;
  logic [msa_pkg::IDX_W-1:0]  pipe_idx_r;
  logic                       hit;
  msa_pkg::acc_t              acc_r;
  logic [msa_pkg::CNT_W-1:0]  n_r;

  // aggregate state and config
  msa_pkg::val_t              cur_r;
  logic                       unknown_r;
  logic [msa_pkg::RC_W-1:0]   rc_r;
  logic [msa_pkg::RC_W-1:0]   rc_inc;
  logic [msa_pkg::LVL_W-1:0]  prev_state_r;
  logic                       seen_r;
  logic [msa_pkg::MODE_W-1:0] mode_r;
  msa_pkg::val_t              warn_r;
  msa_pkg::val_t              crit_r;

  logic                       out_valid_r;
  msa_pkg::val_t              out_val_r;
  logic                       out_unk_r;
  logic [msa_pkg::LVL_W-1:0]  out_lvl_r;
  logic                       out_chg_r;

  logic                       div_start;
  msa_pkg::wide_t             div_dividend;
  logic [msa_pkg::CNT_W-1:0]  div_divisor;
  msa_pkg::wide_t             div_q;
  logic                       div_done;

  logic                       upd_live;
  logic                       due;
  logic                       need_full;
  logic [msa_pkg::LVL_W-1:0]  level;
  logic                       thr_rising;
  logic                       at_crit;
  logic                       at_warn;
  logic                       is_add, is_remove;

  assign hit    = pipe_vld_r && valid_r[pipe_idx_r];
  assign rc_inc = (rc_r < msa_pkg::RC_W'(msa_pkg::RECOMPUTE_LIMIT)) ? (rc_r + 1'b1) : rc_r;
  assign due    = (rc_inc == msa_pkg::RC_W'(msa_pkg::RECOMPUTE_LIMIT));
  assign is_add    = (cmd_r == msa_pkg::CMD_ADD);
  assign is_remove = (cmd_r == msa_pkg::CMD_REMOVE);
  assign upd_live  = (cmd_r == msa_pkg::CMD_UPDATE) && found_r && (ov_r != nv_r);

  assign need_full = due || unknown_r ||
                     ((mode_r == msa_pkg::MODE_MIN) && (nv_r > cur_r) && (cur_r == ov_r)) ||
                     ((mode_r == msa_pkg::MODE_MAX) && (nv_r < cur_r) && (cur_r == ov_r));

  // level of the current aggregate; reversed or equal thresholds count downward
  assign thr_rising = (warn_r < crit_r);
  assign at_crit    = thr_rising ? (cur_r >= crit_r) : (cur_r <= crit_r);
  assign at_warn    = thr_rising ? (cur_r >= warn_r) : (cur_r <= warn_r);

  always_comb begin
    priority if (unknown_r) begin
      level = msa_pkg::LVL_UNKNOWN;
    end else if (at_crit) begin
      level = msa_pkg::LVL_CRITICAL;
    end else if (at_warn) begin
      level = msa_pkg::LVL_WARNING;
    end else begin
      level = msa_pkg::LVL_OK;
    end
  end

  // table write port
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = slot_r;
    mem_wid  = id_r;
    mem_wval = '0;
    if (cmd.exec) begin
      if (is_add && found_r) begin
        mem_we = 1'b1;
      end else if (is_add && free_found_r) begin
        mem_we = 1'b1;
        mem_wa = free_slot_r;
      end else if (upd_live) begin
        mem_we   = 1'b1;
        mem_wval = nv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[mem_wa]  <= mem_wid;
      val_mem[mem_wa] <= mem_wval;
    end
    rd_id_r  <= id_mem[scan_r[msa_pkg::IDX_W-1:0]];
    rd_val_r <= val_mem[scan_r[msa_pkg::IDX_W-1:0]];
  end

  assign div_start    = cmd.div_full_start || cmd.div_part_start;
  assign div_dividend = cmd.div_full_start ?
                        {{(msa_pkg::DW - msa_pkg::ACC_W){acc_r[msa_pkg::ACC_W-1]}}, acc_r} :
                        (msa_pkg::ext_val(nv_r) - msa_pkg::ext_val(ov_r));
  assign div_divisor  = cmd.div_full_start ? n_r : count_r;

  msa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      scan_r       <= '0;
      pipe_vld_r   <= 1'b0;
      cur_r        <= '0;
      unknown_r    <= 1'b1;
      rc_r         <= '0;
      prev_state_r <= msa_pkg::LVL_OK;
      seen_r       <= 1'b0;
      mode_r       <= msa_pkg::MODE_AVG;
      warn_r       <= '0;
      crit_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_r     <= '0;
        pipe_vld_r <= 1'b0;
      end else if (cmd.search_run || cmd.full_run) begin
        if (scan_r != msa_pkg::SCAN_W'(msa_pkg::MAX_METRICS)) begin
          pipe_vld_r <= 1'b1;
          scan_r     <= scan_r + 1'b1;
        end else begin
          pipe_vld_r <= 1'b0;
        end
      end

      if (cmd.exec) begin
        if (is_add && found_r) begin
          rc_r <= msa_pkg::RC_W'(msa_pkg::RECOMPUTE_LIMIT);
        end else if (is_add && free_found_r) begin
          valid_r[free_slot_r] <= 1'b1;
          count_r              <= count_r + 1'b1;
          rc_r                 <= msa_pkg::RC_W'(msa_pkg::RECOMPUTE_LIMIT);
        end else if (is_remove) begin
          if (found_r) begin
            valid_r[slot_r] <= 1'b0;
            count_r         <= count_r - 1'b1;
          end
          rc_r <= msa_pkg::RC_W'(msa_pkg::RECOMPUTE_LIMIT);
        end else if (upd_live) begin
          rc_r <= rc_inc;
          if (!need_full) begin
            unique case (mode_r)
              msa_pkg::MODE_MIN: if (nv_r <= cur_r) cur_r <= nv_r;
              msa_pkg::MODE_MAX: if (nv_r >= cur_r) cur_r <= nv_r;
              msa_pkg::MODE_SUM: cur_r <= msa_pkg::sat_val(msa_pkg::ext_val(cur_r) -
                                           msa_pkg::ext_val(ov_r) + msa_pkg::ext_val(nv_r));
              default: ;
            endcase
          end
        end
      end

      if (cmd.full_fin) begin
        rc_r <= '0;
        if (n_r == '0) begin
          cur_r     <= '0;
          unknown_r <= (mode_r != msa_pkg::MODE_SUM);
        end else if (mode_r != msa_pkg::MODE_AVG) begin
          cur_r     <= msa_pkg::sat_val({{(msa_pkg::DW - msa_pkg::ACC_W){acc_r[msa_pkg::ACC_W-1]}},
                                         acc_r});
          unknown_r <= 1'b0;
        end
      end
      if (cmd.div_full_fin) begin
        cur_r     <= msa_pkg::sat_val(div_q);
        unknown_r <= 1'b0;
      end
      if (cmd.div_part_fin) begin
        cur_r <= msa_pkg::sat_val(msa_pkg::ext_val(cur_r) + div_q);
      end

      if (cmd.emit) begin
        out_valid_r  <= 1'b1;
        prev_state_r <= level;
        seen_r       <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          msa_pkg::REG_MODE: begin
            mode_r <= cfg_data[msa_pkg::MODE_W-1:0];
            rc_r   <= msa_pkg::RC_W'(msa_pkg::RECOMPUTE_LIMIT);
          end
          msa_pkg::REG_WARN: warn_r <= cfg_data;
          msa_pkg::REG_CRIT: crit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pipe_idx_r <= scan_r[msa_pkg::IDX_W-1:0];
    if (cmd.load) begin
      cmd_r        <= in_command;
      id_r         <= in_metric_id;
      nv_r         <= in_metric_value;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.search_run) begin
      if (hit && (rd_id_r == id_r) && !found_r) begin
        found_r <= 1'b1;
        slot_r  <= pipe_idx_r;
        ov_r    <= rd_val_r;
      end
      if (pipe_vld_r && !valid_r[pipe_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= pipe_idx_r;
      end
    end

    if (cmd.scan_start) begin
      acc_r <= '0;
      n_r   <= '0;
    end else if (cmd.full_run && hit) begin
      n_r <= n_r + 1'b1;
      if (n_r == '0) begin
        acc_r <= msa_pkg::acc_of_val(rd_val_r);
      end else begin
        unique case (mode_r)
          msa_pkg::MODE_MIN: if (msa_pkg::acc_of_val(rd_val_r) < acc_r)
                               acc_r <= msa_pkg::acc_of_val(rd_val_r);
          msa_pkg::MODE_MAX: if (msa_pkg::acc_of_val(rd_val_r) > acc_r)
                               acc_r <= msa_pkg::acc_of_val(rd_val_r);
          default:           acc_r <= acc_r + msa_pkg::acc_of_val(rd_val_r);
        endcase
      end
    end

    if (cmd.emit) begin
      out_val_r <= unknown_r ? '0 : cur_r;
      out_unk_r <= unknown_r;
      out_lvl_r <= level;
      out_chg_r <= !seen_r || (prev_state_r != level);
    end
  end

  assign stat.scan_done = (scan_r == msa_pkg::SCAN_W'(msa_pkg::MAX_METRICS)) && !pipe_vld_r;
  assign stat.upd_live  = upd_live;
  assign stat.need_full = need_full;
  assign stat.avg_mode  = (mode_r == msa_pkg::MODE_AVG);
  assign stat.n_zero    = (n_r == '0);
  assign stat.div_done  = div_done;
  assign stat.out_busy  = out_valid_r && out_stall;

  assign out_valid           = out_valid_r;
  assign out_aggregate_value = out_val_r;
  assign out_value_unknown   = out_unk_r;
  assign out_level_state     = out_lvl_r;
  assign out_level_changed   = out_chg_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == msa_pkg::CNT_W'($countones(valid_r)))
    else $error("valid count out of step with valid bits");

  a_rc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= msa_pkg::RC_W'(msa_pkg::RECOMPUTE_LIMIT))
    else $error("recompute counter beyond limit");

  a_full_clears_rc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.full_fin && !cfg_valid) |=> (rc_r == '0))
    else $error("full recompute left counter set");

endmodule

[design/msa_ctrl.sv]
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer: search, table update, full recompute, division and result word.
// ----------------------------------------------------------------------------
module msa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  msa_pkg::dp_stat_t  stat,
  output msa_pkg::dp_cmd_t   cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_EXEC   = 9'b000000100,
    S_FULL   = 9'b000001000,
    S_FFIN   = 9'b000010000,
    S_FDIV   = 9'b000100000,
    S_PDIV   = 9'b001000000,
    S_EMIT   = 9'b010000000,
    S_SPARE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search_run = 1'b1;
        if (stat.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (!stat.upd_live) begin
          state_nxt = S_IDLE;
        end else if (stat.need_full) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_FULL;
        end else if (stat.avg_mode) begin
          cmd.div_part_start = 1'b1;
          state_nxt          = S_PDIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_FULL: begin
        cmd.full_run = 1'b1;
        if (stat.scan_done) state_nxt = S_FFIN;
      end
      S_FFIN: begin
        cmd.full_fin = 1'b1;
        if (stat.avg_mode && !stat.n_zero) begin
          cmd.div_full_start = 1'b1;
          state_nxt          = S_FDIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_FDIV: begin
        if (stat.div_done) begin
          cmd.div_full_fin = 1'b1;
          state_nxt        = S_EMIT;
        end
      end
      S_PDIV: begin
        if (stat.div_done) begin
          cmd.div_part_fin = 1'b1;
          state_nxt        = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the result register can take a new word
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  a_div_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_full_start |=> (state_r == S_FDIV))
    else $error("full-table division not entered");

  a_emit_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !stat.out_busy)
    else $error("result overwritten while stalled");

  a_search_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && stat.scan_done) |=> (state_r == S_EXEC))
    else $error("search did not hand over to table update");

endmodule

[design/metric_set_aggregator.sv]
// ----------------------------------------------------------------------------
// metric_set_aggregator
// Metric table with incremental and full-table aggregate and level state.
// ----------------------------------------------------------------------------
// Sequence: ID search walks all MAX_METRICS entries, then the table update
//   state; add, remove and silent updates end there.
// Full recompute adds a second scan of the table; average adds a divider pass.
// One item at a time: next word accepted only after the last one ends; out_stall can hold it.
// Reset: synchronous; valid bits clear at once, no clearing pass.
module metric_set_aggregator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [msa_pkg::CMD_W-1:0]     in_command,
  input  logic [msa_pkg::ID_W-1:0]      in_metric_id,
  input  logic signed [msa_pkg::VAL_W-1:0] in_metric_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [msa_pkg::VAL_W-1:0] out_aggregate_value,
  output logic                          out_value_unknown,
  output logic [msa_pkg::LVL_W-1:0]     out_level_state,
  output logic                          out_level_changed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msa_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [msa_pkg::VAL_W-1:0]     cfg_data
);

  msa_pkg::dp_cmd_t  cmd;
  msa_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  msa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  msa_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_command          (in_command),
    .in_metric_id        (in_metric_id),
    .in_metric_value     (in_metric_value),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_aggregate_value (out_aggregate_value),
    .out_value_unknown   (out_value_unknown),
    .out_level_state     (out_level_state),
    .out_level_changed   (out_level_changed)
  );

endmodule
